[hdl/efrc_pkg.sv]
`default_nettype none

package efrc_pkg;

  localparam int unsigned FRAME_OVERHEAD = 5;

  localparam int unsigned LEN_W     = 17;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 17;

  localparam logic [BYTE_W-1:0] ESCAPE_BYTE      = 8'h1B;
  localparam logic [BYTE_W-1:0] DSP_ERROR_STATUS = 8'd77;
  localparam logic [BYTE_W-1:0] STATUS_OK        = 8'h00;

  localparam logic [LEN_W-1:0] MAX_FRAME_LENGTH_RST = 17'd65540;

  localparam logic [LEN_W-1:0] POS_ESCAPE  = 17'd0;
  localparam logic [LEN_W-1:0] POS_COMMAND = 17'd1;
  localparam logic [LEN_W-1:0] POS_LEN_LO  = 17'd2;
  localparam logic [LEN_W-1:0] POS_LEN_HI  = 17'd3;
  localparam logic [LEN_W-1:0] POS_STATUS  = 17'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_COMMAND = 1'b0,
    CFG_MAX_FRAME_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK           = 3'd0,
    VERDICT_NO_ESCAPE    = 3'd1,
    VERDICT_BAD_ECHO_LEN = 3'd2,
    VERDICT_CHECKSUM     = 3'd3,
    VERDICT_DSP_ERROR    = 3'd4,
    VERDICT_STATUS_ERROR = 3'd5
  } verdict_e;

  typedef struct packed {
    logic              valid;
    verdict_e          verdict;
    logic [BYTE_W-1:0] device_status;
    logic [LEN_W-1:0]  frame_length;
  } chk_res_t;

endpackage

`default_nettype wire

[hdl/efrc_if.sv]
`default_nettype none

interface efrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface efrc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [7:0]  device_status;
  logic [16:0] frame_length;

  modport source (output valid, output verdict, output device_status, output frame_length,
                  input ready);
  modport sink   (input valid, input verdict, input device_status, input frame_length,
                  output ready);
endinterface

`default_nettype wire

[hdl/efrc_check.sv]
`default_nettype none

module efrc_check
  import efrc_pkg::*;
#(
  parameter int unsigned FrameOverhead = FRAME_OVERHEAD
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic              frame_start_i,
  input  wire logic [BYTE_W-1:0] expected_command_i,
  input  wire logic [LEN_W-1:0]  max_frame_length_i,
  output chk_res_t               res_o
);

  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  total_q, total_d;
  logic [BYTE_W-1:0] low_q, low_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [BYTE_W-1:0] status_q, status_d;
  logic              discarding_q, discarding_d;

  logic              active;
  logic [LEN_W-1:0]  pos;
  logic [LEN_W-1:0]  total_base;
  logic [BYTE_W-1:0] low_base;
  logic [BYTE_W-1:0] xor_base;
  logic [BYTE_W-1:0] status_base;
  logic              fail;
  verdict_e          verdict;
  logic [LEN_W-1:0]  len_out;

  assign active      = frame_start_i || !discarding_q;
  assign pos         = frame_start_i ? '0 : pos_q;
  assign total_base  = frame_start_i ? '0 : total_q;
  assign low_base    = frame_start_i ? '0 : low_q;
  assign xor_base    = frame_start_i ? '0 : xor_q;
  assign status_base = frame_start_i ? '0 : status_q;

  always_comb begin
    pos_d        = pos_q;
    total_d      = total_q;
    low_d        = low_q;
    xor_d        = xor_q;
    status_d     = status_q;
    discarding_d = discarding_q;
    fail         = 1'b0;
    verdict      = VERDICT_OK;
    len_out      = '0;
    if (step_i && active) begin
      pos_d        = pos + 17'd1;
      total_d      = total_base;
      low_d        = low_base;
      xor_d        = xor_base;
      status_d     = status_base;
      discarding_d = 1'b0;
      unique case (pos)
        POS_ESCAPE: begin
          if (rx_byte_i != ESCAPE_BYTE) begin
            fail    = 1'b1;
            verdict = VERDICT_NO_ESCAPE;
          end
        end
        POS_COMMAND: begin
          xor_d = xor_base ^ rx_byte_i;
          if (rx_byte_i != expected_command_i) begin
            fail    = 1'b1;
            verdict = VERDICT_BAD_ECHO_LEN;
          end
        end
        POS_LEN_LO: begin
          xor_d = xor_base ^ rx_byte_i;
          low_d = rx_byte_i;
        end
        POS_LEN_HI: begin
          xor_d   = xor_base ^ rx_byte_i;
          total_d = {1'b0, rx_byte_i, low_base} + LEN_W'(FrameOverhead);
          if (total_d > max_frame_length_i) begin
            fail    = 1'b1;
            verdict = VERDICT_BAD_ECHO_LEN;
            len_out = total_d;
          end
        end
        default: begin
          if (pos == POS_STATUS) begin
            status_d = rx_byte_i;
          end
          if (({1'b0, pos} + 18'd1) == {1'b0, total_base}) begin
            fail    = 1'b1;
            len_out = total_base;
            if (rx_byte_i != xor_base) begin
              verdict = VERDICT_CHECKSUM;
            end else if (status_d == STATUS_OK) begin
              verdict = VERDICT_OK;
            end else if (status_d == DSP_ERROR_STATUS) begin
              verdict = VERDICT_DSP_ERROR;
            end else begin
              verdict = VERDICT_STATUS_ERROR;
            end
          end else begin
            xor_d = xor_base ^ rx_byte_i;
          end
        end
      endcase
      if (fail) begin
        discarding_d = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.valid         = fail;
    res_o.verdict       = verdict;
    res_o.device_status = status_d;
    res_o.frame_length  = len_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      total_q      <= '0;
      low_q        <= '0;
      xor_q        <= '0;
      status_q     <= '0;
      discarding_q <= 1'b1;
    end else begin
      pos_q        <= pos_d;
      total_q      <= total_d;
      low_q        <= low_d;
      xor_q        <= xor_d;
      status_q     <= status_d;
      discarding_q <= discarding_d;
    end
  end

  // a result always ends the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> discarding_q)
    else $error("frame not closed after result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && frame_start_i && !res_o.valid |=> !discarding_q && pos_q == POS_COMMAND)
    else $error("frame start did not restart the frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.verdict == VERDICT_OK |-> res_o.frame_length != '0)
    else $error("good frame without length");

endmodule

`default_nettype wire

[hdl/escape_frame_response_checker.sv]
// a result's last byte is held in the input register, then the result is registered in the output register
// throughput: one byte per cycle unless a waiting result stalls input, at most one result per frame
// a waiting result holds the checker; the input register takes one more byte, then input stalls
// reset: asynchronous, active low; waits for a frame start, expected_command 0,
// max_frame_length 65540
`default_nettype none

module escape_frame_response_checker
  import efrc_pkg::*;
#(
  parameter int unsigned FrameOverhead = FRAME_OVERHEAD
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  efrc_byte_if.sink                 rx_if,
  efrc_result_if.source             res_if,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  logic [BYTE_W-1:0] expected_command_q;
  logic [LEN_W-1:0]  max_frame_length_q;

  logic              s1_valid_q, s1_valid_d;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_start_q;

  logic              out_valid_q, out_valid_d;
  chk_res_t          out_q;

  logic              advance;
  logic              step;
  logic              in_xfer;
  chk_res_t          chk_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_command_q <= '0;
      max_frame_length_q <= MAX_FRAME_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_EXPECTED_COMMAND: expected_command_q <= cfg_data_i[BYTE_W-1:0];
        CFG_MAX_FRAME_LENGTH: max_frame_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = !out_valid_q || res_if.ready;
  assign step        = s1_valid_q && advance;
  assign rx_if.ready = !s1_valid_q || advance;
  assign in_xfer     = rx_if.valid && rx_if.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q  <= rx_if.rx_byte;
      s1_start_q <= rx_if.frame_start;
    end
  end

  efrc_check #(
    .FrameOverhead(FrameOverhead)
  ) u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .rx_byte_i         (s1_byte_q),
    .frame_start_i     (s1_start_q),
    .expected_command_i(expected_command_q),
    .max_frame_length_i(max_frame_length_q),
    .res_o             (chk_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (chk_res.valid) begin
      out_valid_d = 1'b1;
    end else if (res_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_res.valid) begin
      out_q <= chk_res;
    end
  end

  assign res_if.valid         = out_valid_q;
  assign res_if.verdict       = out_q.verdict;
  assign res_if.device_status = out_q.device_status;
  assign res_if.frame_length  = out_q.frame_length;

  // a new result only comes from a byte in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a byte");

  // a stalled byte is neither dropped nor overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_start_q))
    else $error("stalled byte lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_if.ready |-> s1_valid_q && out_valid_q && !res_if.ready)
    else $error("input stalled with room free");

endmodule

`default_nettype wire
